FILE: rtl/rpbd_pkg.sv
// Shared types and constants of the raster predictive byte decoder.
// No dependencies; the interfaces and the top level import it.
package rpbd_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 1;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	localparam cfg_idx_t REG_PLANE_WIDTH  = 1'd0;
	localparam cfg_idx_t REG_PLANE_HEIGHT = 1'd1;

	// Field and register widths, and the frame height limit.
	localparam int DIM_W   = 13;
	localparam int ROW_W   = 12;
	localparam int HEIGHT_LIMIT = 4096;

	typedef logic [7:0]       byte_t;
	typedef logic [DIM_W-1:0] dim_t;
	typedef logic [ROW_W-1:0] row_t;

endpackage

FILE: rtl/rpbd_if.sv
// Handshake channels of the raster predictive byte decoder.
// Depends on rpbd_pkg for payload types.

// Residual input channel.
interface rpbd_in_if
	import rpbd_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t residual;

	modport source (output valid, output residual, input ready);
	modport sink (input valid, input residual, output ready);
endinterface

// Reconstructed pixel output channel.
interface rpbd_out_if
	import rpbd_pkg::*;
();
	logic  valid;
	logic  ready;
	byte_t pixel_value;
	logic  frame_end;

	modport source (output valid, output pixel_value, output frame_end, input ready);
	modport sink (input valid, input pixel_value, input frame_end, output ready);
endinterface

// Configuration write channel.
interface rpbd_cfg_if
	import rpbd_pkg::*;
();
	logic     valid;
	logic     ready;
	cfg_idx_t index;
	dim_t     data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: rtl/raster_predictive_byte_decoder.sv
// Raster predictive byte decoder: rebuilds a byte plane from residuals.
// Depends on rpbd_pkg and the channel interfaces in rpbd_if.sv.
//
// The decoder takes one residual byte per transaction in raster order and
// returns one reconstructed byte per transaction, with frame_end set on the
// last pixel of a frame. It sustains one transaction per clock while the
// output is taken. Stage 1 retires an accepted residual into the output
// register, which holds it until taken. The input stalls only while stage 1
// and the output register are both full and the output is not taken. The
// previous row lives in a single-port-per-side synchronous memory of MAX_WIDTH
// bytes: the above pixel is read when the residual is accepted and the new
// pixel is written when stage 1 retires, with a bypass for a width of one
// where consecutive pixels share the same entry. Plane sizes are written
// through the configuration channel and take effect on the next pixel; the
// user must write them only while the decoder is idle, which the block does
// not enforce. The row memory is not cleared after reset, so a width raised
// in the middle of a frame must not reach entries that were never written.
module raster_predictive_byte_decoder
	import rpbd_pkg::*;
#(
	parameter int MAX_WIDTH = 4096
) (
	input logic       clk,
	input logic       arst_n,
	rpbd_cfg_if.sink  cfg,
	rpbd_in_if.sink   pix_in,
	rpbd_out_if.source pix_out
);

	localparam int COL_W = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int CMP_W = (COL_W > DIM_W) ? COL_W : DIM_W;
	typedef logic [COL_W-1:0] col_t;
	typedef logic [CMP_W-1:0] cmp_t;

	// Configuration registers.
	dim_t plane_width_q;
	dim_t plane_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_width_q  <= DIM_W'(640);
			plane_height_q <= DIM_W'(480);
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				REG_PLANE_WIDTH:  plane_width_q  <= cfg.data;
				REG_PLANE_HEIGHT: plane_height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	assign cfg.ready = 1'b1;

	// Last column and last row indexes after clamping the sizes.
	cmp_t last_col;
	row_t last_row;

	always_comb begin
		if (plane_width_q == '0) begin
			last_col = '0;
		end else if (32'(plane_width_q) > MAX_WIDTH) begin
			last_col = CMP_W'(MAX_WIDTH - 1);
		end else begin
			last_col = CMP_W'(plane_width_q) - CMP_W'(1);
		end
		if (plane_height_q == '0) begin
			last_row = '0;
		end else if (32'(plane_height_q) > HEIGHT_LIMIT) begin
			last_row = ROW_W'(HEIGHT_LIMIT - 1);
		end else begin
			last_row = ROW_W'(plane_height_q - DIM_W'(1));
		end
	end

	// Raster position of the next pixel.
	col_t col_q;
	row_t row_q;

	logic s1_valid_q;
	logic s1_adv;
	logic in_acc;
	logic out_valid_q;
	logic row_last;
	logic col_last;

	assign s1_adv       = s1_valid_q && (!out_valid_q || pix_out.ready);
	assign pix_in.ready = !s1_valid_q || s1_adv;
	assign in_acc       = pix_in.valid && pix_in.ready;
	assign col_last     = CMP_W'(col_q) >= last_col;
	assign row_last     = row_q >= last_row;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_acc) begin
			if (col_last) begin
				col_q <= '0;
				row_q <= row_last ? '0 : row_q + ROW_W'(1);
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// Stage 1 holds the accepted residual while the above pixel is read.
	col_t  col_s1;
	byte_t residual_s1;
	logic  top_row_s1;
	logic  left_col_s1;
	logic  frame_end_s1;
	logic  fwd_s1;
	byte_t fwd_pix_s1;
	byte_t above_rd_q;
	byte_t left_q;
	byte_t pix;

	byte_t prior_row_mem [MAX_WIDTH];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			col_s1       <= col_q;
			residual_s1  <= pix_in.residual;
			top_row_s1   <= (row_q == '0);
			left_col_s1  <= (col_q == '0);
			frame_end_s1 <= col_last && row_last;
			// The write of the pixel ahead lands on the entry being read.
			fwd_s1       <= s1_adv && (col_s1 == col_q);
			fwd_pix_s1   <= pix;
		end
	end

	// Previous row memory: read at acceptance, written when stage 1 retires.
	always_ff @(posedge clk) begin
		if (in_acc) begin
			above_rd_q <= prior_row_mem[col_q];
		end
		if (s1_adv) begin
			prior_row_mem[col_s1] <= pix;
		end
	end

	// Prediction and reconstruction.
	byte_t above;
	logic [8:0] sum;

	always_comb begin
		above = fwd_s1 ? fwd_pix_s1 : above_rd_q;
		sum   = {1'b0, above} + {1'b0, left_q};
		if (top_row_s1 && left_col_s1) begin
			pix = residual_s1;
		end else if (top_row_s1) begin
			pix = left_q - residual_s1;
		end else if (left_col_s1) begin
			pix = above - residual_s1;
		end else begin
			pix = sum[8:1] - residual_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q <= '0;
		end else if (s1_adv) begin
			left_q <= pix;
		end
	end

	// Output register.
	byte_t pixel_q;
	logic  frame_end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv) begin
			out_valid_q <= 1'b1;
		end else if (pix_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			pixel_q     <= pix;
			frame_end_q <= frame_end_s1;
		end
	end

	assign pix_out.valid       = out_valid_q;
	assign pix_out.pixel_value = pixel_q;
	assign pix_out.frame_end   = frame_end_q;

	// A stalled stage 1 keeps its pixel and its memory address.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !s1_adv |=> s1_valid_q && $stable(col_s1))
		else $error("stage 1 lost its pixel while stalled");

	// The input stalls only when both stage 1 and the output are full.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_in.ready |-> s1_valid_q && out_valid_q)
		else $error("input stalled with room in the pipeline");

	// The last pixel of a frame returns the raster position to the origin.
	a_frame_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && col_last && row_last |=> col_q == '0 && row_q == '0)
		else $error("raster position did not wrap at frame end");

	// The bypass is only taken for a pixel in stage 1.
	a_fwd: assert property (@(posedge clk) disable iff (!arst_n)
		$past(in_acc) && fwd_s1 |-> s1_valid_q && $past(s1_adv))
		else $error("bypass selected without a retiring write");

endmodule

FILE: verif/tb_raster_predictive_byte_decoder.sv
`timescale 1ns / 100ps
// Testbench for raster_predictive_byte_decoder: directed and random residual streams,
// with every pixel checked against a decoder model kept inside the bench.
// Depends on rpbd_pkg, the channel interfaces in rpbd_if.sv and the decoder RTL.

module tb_raster_predictive_byte_decoder;
	import rpbd_pkg::*;

	localparam int PLANE_MAX = 4096;
	localparam int IDLE_PCT  = 27;

	typedef struct packed {
		byte_t pixel;
		logic  end_flag;
	} pixel_exp_t;

	// Decoder model plus the queue of pixels it has predicted but not yet seen.
	class pixel_scoreboard;
		byte_t      above_row[PLANE_MAX];
		bit         above_set[PLANE_MAX];
		byte_t      left_pix;
		int         col_cnt;
		int         row_cnt;
		dim_t       width_reg;
		dim_t       height_reg;
		pixel_exp_t pending_pixels[$];
		int         errors;

		function new();
			width_reg  = 13'd640;
			height_reg = 13'd480;
			left_pix   = 8'h00;
			col_cnt    = 0;
			row_cnt    = 0;
			errors     = 0;
			foreach (above_row[i]) begin
				above_row[i] = 8'h00;
				above_set[i] = 1'b0;
			end
		endfunction

		// Zero counts as one, and anything past the limit is held at the limit.
		function int clamp_dim(dim_t d, int hi);
			int v;
			v = d;
			if (v == 0) begin
				return 1;
			end
			if (v > hi) begin
				return hi;
			end
			return v;
		endfunction

		function void write_reg(cfg_idx_t idx, dim_t d);
			case (idx)
				REG_PLANE_WIDTH: width_reg = d;
				REG_PLANE_HEIGHT: height_reg = d;
				default: ;
			endcase
		endfunction

		// A wider row must not reach row-buffer entries that were never written.
		function bit width_ok(dim_t d);
			int nw;
			nw = clamp_dim(d, PLANE_MAX);
			if (row_cnt == 0) begin
				return 1'b1;
			end
			for (int c = 0; c < nw; c++) begin
				if (!above_set[c]) begin
					return 1'b0;
				end
			end
			return 1'b1;
		endfunction

		function bit at_origin();
			return (col_cnt == 0) && (row_cnt == 0);
		endfunction

		function int pending();
			return pending_pixels.size();
		endfunction

		// Rebuild the pixel for one accepted residual and advance the raster position.
		function void note_residual(byte_t r);
			int         w;
			int         h;
			logic [8:0] pair_sum;
			pixel_exp_t e;
			w = clamp_dim(width_reg, PLANE_MAX);
			h = clamp_dim(height_reg, HEIGHT_LIMIT);
			pair_sum = {1'b0, above_row[col_cnt]} + {1'b0, left_pix};
			if (row_cnt == 0 && col_cnt == 0) begin
				e.pixel = r;
			end else if (row_cnt == 0) begin
				e.pixel = left_pix - r;
			end else if (col_cnt == 0) begin
				e.pixel = above_row[col_cnt] - r;
			end else begin
				e.pixel = pair_sum[8:1] - r;
			end
			above_row[col_cnt] = e.pixel;
			above_set[col_cnt] = 1'b1;
			left_pix = e.pixel;
			e.end_flag = 1'b0;
			if (col_cnt >= w - 1) begin
				col_cnt = 0;
				if (row_cnt >= h - 1) begin
					row_cnt = 0;
					e.end_flag = 1'b1;
				end else begin
					row_cnt++;
				end
			end else begin
				col_cnt++;
			end
			pending_pixels.push_back(e);
		endfunction

		// Compare one output transaction with the oldest predicted pixel.
		function void check_pixel(byte_t p, logic fe);
			pixel_exp_t e;
			if (pending_pixels.size() == 0) begin
				$display("%0t: unexpected pixel, expected none, actual pixel_value %0h frame_end %0b",
					$time, p, fe);
				errors++;
				return;
			end
			e = pending_pixels.pop_front();
			if (p !== e.pixel) begin
				$display("%0t: pixel_value mismatch, expected %0h, actual %0h", $time, e.pixel, p);
				errors++;
			end
			if (fe !== e.end_flag) begin
				$display("%0t: frame_end mismatch, expected %0b, actual %0b", $time, e.end_flag, fe);
				errors++;
			end
		endfunction
	endclass

	bit   clk = 1'b0;
	logic arst_n;
	bit   idle_en;
	bit   stall_request;
	int   random_sent;

	pixel_scoreboard board = new();

	rpbd_cfg_if cfg_ch ();
	rpbd_in_if  in_ch ();
	rpbd_out_if out_ch ();

	raster_predictive_byte_decoder DUT (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.pix_in  (in_ch),
		.pix_out (out_ch)
	);

	// 20 ns clock.
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Pixel receiver: random back-pressure, and one long hold-off on request.
	initial begin
		forever begin
			@(negedge clk);
			if (stall_request) begin
				stall_request = 1'b0;
				out_ch.ready <= 1'b0;
				for (int i = 1; i < 300; i++) begin
					@(negedge clk);
				end
			end else begin
				out_ch.ready <= !(idle_en && ($urandom_range(0, 99) < IDLE_PCT));
			end
		end
	end

	// Every accepted pixel transaction goes to the scoreboard.
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			board.check_pixel(out_ch.pixel_value, out_ch.frame_end);
		end
	end

	// Offer one residual, with random idle cycles ahead of it. Called and returns at a
	// falling edge; valid stays high so back-to-back transactions need no gap.
	task automatic send_residual(byte_t r);
		while (idle_en && ($urandom_range(0, 99) < IDLE_PCT)) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid    <= 1'b1;
		in_ch.residual <= r;
		@(posedge clk);
		while (!in_ch.ready) begin
			@(posedge clk);
		end
		board.note_residual(r);
		@(negedge clk);
	endtask

	task automatic send_random(int n);
		repeat (n) begin
			send_residual(byte_t'($urandom));
		end
	endtask

	// Send residuals until the frame in progress is complete.
	task automatic finish_frame();
		while (!board.at_origin()) begin
			send_residual(byte_t'($urandom));
		end
	endtask

	// Stop offering residuals and wait until every predicted pixel has come out.
	task automatic drain();
		in_ch.valid <= 1'b0;
		while (board.pending() != 0) begin
			@(posedge clk);
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic cfg_write(cfg_idx_t idx, dim_t d);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= d;
		@(posedge clk);
		while (!cfg_ch.ready) begin
			@(posedge clk);
		end
		board.write_reg(idx, d);
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
		@(negedge clk);
	endtask

	// Set the plane size; the decoder must be idle. If the new width would reach
	// row-buffer entries never written, a height of one first ends the frame with
	// the current row, and that row is completed.
	task automatic set_plane(dim_t w, dim_t h);
		if (!board.width_ok(w)) begin
			cfg_write(REG_PLANE_HEIGHT, 13'd1);
			finish_frame();
			drain();
		end
		cfg_write(REG_PLANE_WIDTH, w);
		cfg_write(REG_PLANE_HEIGHT, h);
	endtask

	// Stimulus.
	initial begin
		int   n;
		int   phase;
		dim_t w;
		dim_t h;
		arst_n          = 1'b0;
		in_ch.valid     = 1'b0;
		in_ch.residual  = 8'h00;
		cfg_ch.valid    = 1'b0;
		cfg_ch.index    = REG_PLANE_WIDTH;
		cfg_ch.data     = '0;
		out_ch.ready    = 1'b0;
		idle_en         = 1'b1;
		stall_request   = 1'b0;
		random_sent     = 0;
		repeat (12) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset sizes: the first pixel is the residual itself, then left minus residual.
		send_residual(8'h00);
		send_residual(8'hFF);
		send_residual(8'h80);
		drain();

		// Narrowing mid-row ends the row on the next pixel; later rows use above and average.
		set_plane(13'd2, 13'd3);
		send_residual(8'h01);
		send_residual(8'hFF);
		send_residual(8'h00);
		send_residual(8'hFF);
		send_residual(8'h00);
		drain();

		// Width of one: only the above predictor after the first pixel.
		set_plane(13'd1, 13'd4);
		send_random(4);
		drain();

		// Zero sizes act as one, so every pixel ends a frame.
		set_plane(13'd0, 13'd0);
		send_residual(8'h7F);
		send_residual(8'hFF);
		drain();

		// All-255 neighbors push the average sum to its top bit.
		set_plane(13'd5, 13'd2);
		send_residual(8'hFF);
		repeat (4) send_residual(8'h00);
		send_residual(8'h00);
		send_residual(8'hFF);
		send_residual(8'h00);
		send_residual(8'h01);
		send_residual(8'h80);
		drain();

		// Random phases: sizes change between phases, often in the middle of a frame.
		phase = 0;
		while (random_sent < 1000) begin
			drain();
			idle_en = (phase != 5);
			if (phase == 8) begin
				// Widest row, clamped from the all-ones register value.
				set_plane(13'h1FFF, 13'd1);
			end else if (phase == 12) begin
				// Tallest frame, one pixel wide.
				set_plane(13'd1, 13'h1FFF);
			end else begin
				if ($urandom_range(0, 9) == 0) begin
					w = dim_t'($urandom_range(0, 1));
				end else if (phase > 8 && $urandom_range(0, 7) == 0) begin
					w = dim_t'($urandom_range(25, 8191));
				end else begin
					w = dim_t'($urandom_range(2, 24));
				end
				if (phase > 8 && $urandom_range(0, 15) == 0) begin
					h = dim_t'($urandom_range(0, 8191));
				end else begin
					h = dim_t'($urandom_range(0, 6));
				end
				set_plane(w, h);
				if (phase == 3) begin
					stall_request = 1'b1;
				end
			end
			n = $urandom_range(20, 80);
			send_random(n);
			random_sent += n;
			phase++;
		end
		idle_en = 1'b1;

		drain();
		repeat (10) @(negedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	// Run limit.
	initial begin
		#5000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

FILE: raster_predictive_byte_decoder.f
rtl/rpbd_pkg.sv
rtl/rpbd_if.sv
rtl/raster_predictive_byte_decoder.sv
verif/tb_raster_predictive_byte_decoder.sv
